// ----- sv/ept_pkg.sv -----
// shared package of the enhanced pll tracker
// fixed-point constants, config register codes, saturation and trig table functions
// no dependencies
package ept_pkg;

  localparam int TRIG_BITS_DEF = 10;
  localparam int XW = 48;

  localparam logic [18:0] TWO_PI_Q  = 19'd411775;
  localparam logic [18:0] HALF_PI_Q = 19'd102944;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [18:0] MOD_C48 = 19'((64'd1 << XW) % 64'd411775);

  localparam logic [11:0] ADC_OFFSET_RST = 12'd1850;
  localparam logic [30:0] VPC_RST = 31'd2880;

  typedef enum logic [2:0] {
    CFG_ADC_OFFSET = 3'd0,
    CFG_VPC        = 3'd1,
    CFG_PROP_GAIN  = 3'd2,
    CFG_INTEG_GAIN = 3'd3,
    CFG_STEP_SIZE  = 3'd4,
    CFG_NOM_OMEGA  = 3'd5,
    CFG_AMP_GAIN   = 3'd6,
    CFG_CLAMP      = 3'd7
  } cfg_idx_t;

  function automatic logic signed [31:0] sat_prod(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_prod(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v >>> 16;
    return sat_prod(s);
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    else if (v < -33'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_lim(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic [30:0] lim);
    logic signed [33:0] v;
    logic signed [33:0] l;
    v = 34'(a) + 34'(b);
    l = $signed({3'b000, lim});
    if (v > l) return $signed({1'b0, lim});
    else if (v < -l) return 32'(-l);
    else return v[31:0];
  endfunction

  // quarter-wave sine, taylor series to x^11 in q30, rounded to q16.16
  function automatic logic [16:0] quarter_sin(input logic [63:0] r, input int qb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    x  = (r * HALF_PI_Q30) >> qb;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    y  = (((x * t) >> 30) + 64'd8192) >> 14;
    return y[16:0];
  endfunction

endpackage

// ----- sv/ept_if.sv -----
// channel interfaces of the enhanced pll tracker
// sample channel and result channel, valid/ready handshake
interface ept_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] adc_sample;
  modport source(output valid, output adc_sample, input ready);
  modport sink(input valid, input adc_sample, output ready);
endinterface

interface ept_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fitted_voltage;
  logic [18:0]        phase_angle;
  logic signed [31:0] amplitude;
  logic signed [31:0] track_error;
  modport source(output valid, output fitted_voltage, output phase_angle,
                 output amplitude, output track_error, input ready);
  modport sink(input valid, input fitted_voltage, input phase_angle,
               input amplitude, input track_error, output ready);
endinterface

// ----- sv/ept_mul.sv -----
// bit-serial signed 32x32 multiplier, one multiplier bit per cycle
// uses nothing from the package
module ept_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [63:0] prod
);

  logic signed [31:0] a_r;
  logic [31:0]        b_r;
  logic signed [32:0] hi_r;
  logic [31:0]        lo_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic signed [33:0] addend;
  logic signed [33:0] t;

  always_comb begin
    if (b_r[0]) begin
      addend = (cnt_r == 5'd31) ? -34'(a_r) : 34'(a_r);
    end else begin
      addend = '0;
    end
    t = 34'(hi_r) + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (busy_r) begin
      hi_r <= t[33:1];
      lo_r <= {t[0], lo_r[31:1]};
      b_r  <= {1'b0, b_r[31:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r[31:0], lo_r};

endmodule

// ----- sv/ept_rdiv.sv -----
// bit-serial restoring division by two pi (q16.16), one quotient bit per cycle
// depends on ept_pkg for the divisor and the word width
module ept_rdiv
  import ept_pkg::*;
#(
  parameter int QW = TRIG_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [18:0]   rem0,
  input  logic [XW-1:0] word,
  input  logic [5:0]    nbits,
  output logic          done,
  output logic [18:0]   rem,
  output logic [QW-1:0] quot
);

  logic [18:0]   rem_r;
  logic [XW-1:0] word_r;
  logic [QW-1:0] q_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [19:0]   t;
  logic          ge;

  assign t  = {rem_r, word_r[XW-1]};
  assign ge = (t >= {1'b0, TWO_PI_Q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= rem0;
      word_r <= word;
    end else if (busy_r) begin
      rem_r  <= ge ? 19'(t - {1'b0, TWO_PI_Q}) : t[18:0];
      word_r <= {word_r[XW-2:0], 1'b0};
      q_r    <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign quot = q_r;

endmodule

// ----- sv/ept_sincos.sv -----
// registered sine and cosine lookup from a quarter-wave table with quadrant folding
// depends on ept_pkg for the table function
module ept_sincos
  import ept_pkg::*;
#(
  parameter int TB = TRIG_BITS_DEF
) (
  input  logic               clk,
  input  logic               load,
  input  logic [TB-1:0]      idx,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int Q = 1 << (TB - 2);

  logic [16:0]        qtab [Q+1];
  logic [TB-2:0]      rs;
  logic [TB-2:0]      rc;
  logic signed [31:0] s;
  logic signed [31:0] c;
  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_nxt;
  logic signed [31:0] cos_nxt;

  for (genvar g = 0; g <= Q; g++) begin : g_tab
    assign qtab[g] = quarter_sin(64'(g), TB - 2);
  end

  assign rs = {1'b0, idx[TB-3:0]};
  assign rc = (TB-1)'(Q) - rs;
  assign s  = {15'b0, qtab[rs]};
  assign c  = {15'b0, qtab[rc]};

  always_comb begin
    unique case (idx[TB-1:TB-2])
      2'd0: begin sin_nxt = s;  cos_nxt = c;  end
      2'd1: begin sin_nxt = c;  cos_nxt = -s; end
      2'd2: begin sin_nxt = -s; cos_nxt = -c; end
      2'd3: begin sin_nxt = -c; cos_nxt = s;  end
      default: begin sin_nxt = s; cos_nxt = c; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ----- sv/enhanced_pll_tracker_unit.sv -----
// Enhanced single-phase PLL tracker: per 12-bit sample it returns the fitted voltage, the
// amplitude estimate and the tracking error in Q16.16 and the wrapped phase in unsigned Q3.16.
// One sample is in work at a time. The next sample can be taken in the same cycle as a result
// becomes valid. The work per sample is ten products that go one after the other through a
// single bit-serial multiplier, the bit-serial modulo-2pi reduction, the phase-to-table index
// division after it and four further steps. The index division of the old phase runs beside
// the first product. The next sample is taken while a result still waits on the output; the
// one after that waits until the result leaves. The user must write gains and limits through
// the cfg port only while the block is idle; the block itself does not enforce this.
module enhanced_pll_tracker_unit
  import ept_pkg::*;
#(
  parameter int TRIG_TABLE_BITS = TRIG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ept_in_if.sink            in_ch,
  ept_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_VIN  = 17'h00002,
    S_ERR  = 17'h00004,
    S_ESIN = 17'h00008,
    S_K    = 17'h00010,
    S_T    = 17'h00020,
    S_P    = 17'h00040,
    S_SUM  = 17'h00080,
    S_INC  = 17'h00100,
    S_MOD  = 17'h00200,
    S_FIX  = 17'h00400,
    S_IDX  = 17'h00800,
    S_PRE  = 17'h01000,
    S_A1   = 17'h02000,
    S_AMP  = 17'h04000,
    S_FIT  = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic [11:0]        adc_off_r;
  logic [30:0]        vpc_r;
  logic signed [31:0] prop_r;
  logic signed [31:0] integ_r;
  logic [30:0]        step_r;
  logic signed [31:0] nom_r;
  logic signed [31:0] ampg_r;
  logic [30:0]        clamp_r;

  // loop state
  logic signed [31:0] pi_int_r;
  logic signed [31:0] pi_last_r;
  logic [18:0]        accum_r;
  logic signed [31:0] freq_last_r;
  logic signed [31:0] amp_int_r;
  logic signed [31:0] amp_last_r;
  logic [18:0]        phase_r;
  logic signed [31:0] fitted_r;

  // per-sample work registers
  logic signed [12:0] counts_r;
  logic signed [31:0] vin_r;
  logic signed [31:0] err_r;
  logic signed [31:0] esin_r;
  logic signed [31:0] k_r;
  logic signed [31:0] t_r;
  logic signed [31:0] p_r;
  logic signed [31:0] piout_r;
  logic [XW-1:0]      x_r;
  logic signed [31:0] pre_r;
  logic signed [31:0] a1_r;
  logic signed [31:0] amp_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] o_fit_r;
  logic [18:0]        o_phase_r;
  logic signed [31:0] o_amp_r;
  logic signed [31:0] o_err_r;

  logic               mul_launch_r;
  logic               div_launch_r;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_done;
  logic signed [63:0] mul_prod;
  logic [18:0]        div_rem0;
  logic [XW-1:0]      div_word;
  logic [5:0]         div_nbits;
  logic               div_done;
  logic [18:0]        div_rem;
  logic [TRIG_TABLE_BITS-1:0] div_quot;
  logic               sc_load;
  logic signed [31:0] sin_v;
  logic signed [31:0] cos_v;
  logic [19:0]        fix_v;
  logic               in_acc;
  logic               out_free;

  function automatic logic is_mul(input state_t s);
    return (s == S_VIN) || (s == S_ESIN) || (s == S_K) || (s == S_T) || (s == S_P) ||
           (s == S_INC) || (s == S_PRE) || (s == S_A1) || (s == S_AMP) || (s == S_FIT);
  endfunction

  function automatic logic is_div(input state_t s);
    return (s == S_VIN) || (s == S_MOD) || (s == S_IDX);
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  ept_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_launch_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ept_rdiv #(.QW(TRIG_TABLE_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_launch_r),
    .rem0  (div_rem0),
    .word  (div_word),
    .nbits (div_nbits),
    .done  (div_done),
    .rem   (div_rem),
    .quot  (div_quot)
  );

  assign sc_load = div_done && ((state_r == S_VIN) || (state_r == S_IDX));

  ept_sincos #(.TB(TRIG_TABLE_BITS)) u_sc (
    .clk   (clk),
    .load  (sc_load),
    .idx   (div_quot),
    .sin_o (sin_v),
    .cos_o (cos_v)
  );

  // multiplier operands
  always_comb begin
    unique case (state_r)
      S_VIN:   begin mul_a = 32'(counts_r);  mul_b = {1'b0, vpc_r};  end
      S_ESIN:  begin mul_a = err_r;          mul_b = sin_v;          end
      S_K:     begin mul_a = integ_r;        mul_b = {1'b0, step_r}; end
      S_T:     begin mul_a = k_r;            mul_b = pi_int_r;       end
      S_P:     begin mul_a = esin_r;         mul_b = prop_r;         end
      S_INC:   begin mul_a = freq_last_r;    mul_b = {1'b0, step_r}; end
      S_PRE:   begin mul_a = cos_v;          mul_b = err_r;          end
      S_A1:    begin mul_a = ampg_r;         mul_b = amp_int_r;      end
      S_AMP:   begin mul_a = a1_r;           mul_b = {1'b0, step_r}; end
      S_FIT:   begin mul_a = amp_r;          mul_b = cos_v;          end
      default: begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  // divider operands
  always_comb begin
    if (state_r == S_MOD) begin
      div_rem0  = '0;
      div_word  = x_r;
      div_nbits = 6'(XW);
    end else begin
      div_rem0  = phase_r;
      div_word  = '0;
      div_nbits = 6'(TRIG_TABLE_BITS);
    end
  end

  // wrap fixup for a negative sum
  always_comb begin
    if (!x_r[XW-1]) begin
      fix_v = {1'b0, div_rem};
    end else if (div_rem >= MOD_C48) begin
      fix_v = {1'b0, div_rem} - {1'b0, MOD_C48};
    end else begin
      fix_v = {1'b0, div_rem} + {1'b0, TWO_PI_Q} - {1'b0, MOD_C48};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_VIN;
      S_VIN:   if (mul_done) state_nxt = S_ERR;
      S_ERR:   state_nxt = S_ESIN;
      S_ESIN:  if (mul_done) state_nxt = S_K;
      S_K:     if (mul_done) state_nxt = S_T;
      S_T:     if (mul_done) state_nxt = S_P;
      S_P:     if (mul_done) state_nxt = S_SUM;
      S_SUM:   state_nxt = S_INC;
      S_INC:   if (mul_done) state_nxt = S_MOD;
      S_MOD:   if (div_done) state_nxt = S_FIX;
      S_FIX:   state_nxt = S_IDX;
      S_IDX:   if (div_done) state_nxt = S_PRE;
      S_PRE:   if (mul_done) state_nxt = S_A1;
      S_A1:    if (mul_done) state_nxt = S_AMP;
      S_AMP:   if (mul_done) state_nxt = S_FIT;
      S_FIT:   if (mul_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mul_launch_r <= 1'b0;
      div_launch_r <= 1'b0;
      out_valid_r  <= 1'b0;
      adc_off_r    <= ADC_OFFSET_RST;
      vpc_r        <= VPC_RST;
      prop_r       <= '0;
      integ_r      <= '0;
      step_r       <= '0;
      nom_r        <= '0;
      ampg_r       <= '0;
      clamp_r      <= '0;
      pi_int_r     <= '0;
      pi_last_r    <= '0;
      accum_r      <= '0;
      freq_last_r  <= '0;
      amp_int_r    <= '0;
      amp_last_r   <= '0;
      phase_r      <= HALF_PI_Q;
      fitted_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      mul_launch_r <= is_mul(state_nxt) && (state_nxt != state_r);
      div_launch_r <= is_div(state_nxt) && (state_nxt != state_r);

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_ADC_OFFSET: adc_off_r <= cfg_wdata[11:0];
          CFG_VPC:        vpc_r     <= cfg_wdata[30:0];
          CFG_PROP_GAIN:  prop_r    <= cfg_wdata;
          CFG_INTEG_GAIN: integ_r   <= cfg_wdata;
          CFG_STEP_SIZE:  step_r    <= cfg_wdata[30:0];
          CFG_NOM_OMEGA:  nom_r     <= cfg_wdata;
          CFG_AMP_GAIN:   ampg_r    <= cfg_wdata;
          CFG_CLAMP:      clamp_r   <= cfg_wdata[30:0];
          default:        ;
        endcase
      end

      if (state_r == S_ERR) begin
        pi_int_r  <= clamp_lim(pi_int_r, pi_last_r, clamp_r);
        amp_int_r <= clamp_lim(amp_int_r, amp_last_r, clamp_r);
      end
      if (state_r == S_SUM) begin
        pi_last_r <= esin_r;
      end
      if ((state_r == S_INC) && mul_done) begin
        freq_last_r <= sat_sum(33'(piout_r) + 33'(nom_r));
      end
      if (state_r == S_FIX) begin
        accum_r <= fix_v[18:0];
        phase_r <= fix_v[18:0];
      end
      if ((state_r == S_FIT) && mul_done) begin
        fitted_r <= q_prod(mul_prod);
      end

      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        amp_last_r  <= pre_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      counts_r <= $signed({1'b0, in_ch.adc_sample}) - $signed({1'b0, adc_off_r});
    end
    if (mul_done) begin
      unique case (state_r)
        S_VIN:   vin_r  <= sat_prod(mul_prod);
        S_ESIN:  esin_r <= q_prod(mul_prod);
        S_K:     k_r    <= q_prod(mul_prod);
        S_T:     t_r    <= q_prod(mul_prod);
        S_P:     p_r    <= q_prod(mul_prod);
        S_INC:   x_r    <= XW'(mul_prod[63:16]) + {{(XW-19){1'b0}}, accum_r};
        S_PRE:   pre_r  <= q_prod(mul_prod);
        S_A1:    a1_r   <= q_prod(mul_prod);
        S_AMP:   amp_r  <= q_prod(mul_prod);
        default: ;
      endcase
    end
    if (state_r == S_ERR) begin
      err_r <= sat_sum(33'(vin_r) - 33'(fitted_r));
    end
    if (state_r == S_SUM) begin
      piout_r <= sat_sum(33'(p_r) + 33'(t_r));
    end
    if ((state_r == S_OUT) && out_free) begin
      o_fit_r   <= fitted_r;
      o_phase_r <= phase_r;
      o_amp_r   <= amp_r;
      o_err_r   <= err_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.fitted_voltage = o_fit_r;
  assign out_ch.phase_angle    = o_phase_r;
  assign out_ch.amplitude      = o_amp_r;
  assign out_ch.track_error    = o_err_r;

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_VIN))
    else $error("accepted transaction did not start the sample sequence");

  a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < TWO_PI_Q)
    else $error("phase left the 0..2pi range");

  a_result_load : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_launch_idle : assert property (@(posedge clk) disable iff (!rst_n)
    mul_launch_r |-> !mul_done && is_mul(state_r))
    else $error("multiply launched outside a multiply step");

endmodule
